FILE: hdl/olst_pkg.sv
// Shared types and constants for the ordered list engine.
`default_nettype none
package olst_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;

	// Command codes
	typedef enum logic [3:0] {
		CMD_CREATE    = 4'd0,
		CMD_DISPLAY   = 4'd1,
		CMD_INS_FRONT = 4'd2,
		CMD_DEL_FRONT = 4'd3,
		CMD_INS_BACK  = 4'd4,
		CMD_DEL_BACK  = 4'd5,
		CMD_INS_AT    = 4'd6,
		CMD_DEL_AT    = 4'd7,
		CMD_SEARCH    = 4'd8
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_EMPTY   = 3'd1,
		STS_CREATED = 3'd2,
		STS_RANGE   = 3'd3,
		STS_FULL    = 3'd4
	} status_t;

	// Controller states
	typedef enum logic {
		LS_IDLE,
		LS_DISP
	} lst_state_t;

	// Next-value source of one cell
	typedef enum logic [2:0] {
		CS_HOLD,
		CS_LEFT,
		CS_RIGHT,
		CS_KEY,
		CS_WRAP
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      active;
		logic      tap;
	} cell_ctl_t;

	typedef struct packed {
		logic [3:0]               command;
		logic signed [DATA_W-1:0] value;
		logic [4:0]               position;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [2:0]               status;
		logic                     found;
		logic                     last;
	} rsp_item_t;

endpackage
`default_nettype wire

FILE: hdl/olst_cell.sv
// One storage cell of the list chain: shift mux, element register, key compare.
`default_nettype none
module olst_cell (
	input  wire                               clk,
	input  wire olst_pkg::cell_ctl_t          ctl,
	input  wire logic [olst_pkg::DATA_W-1:0]  left_in,
	input  wire logic [olst_pkg::DATA_W-1:0]  right_in,
	input  wire logic [olst_pkg::DATA_W-1:0]  head_in,
	input  wire logic [olst_pkg::DATA_W-1:0]  key_in,
	output logic      [olst_pkg::DATA_W-1:0]  value_out,
	output logic                              hit,
	output logic      [olst_pkg::DATA_W-1:0]  tap_out
);
	import olst_pkg::*;

	logic [DATA_W-1:0] elem_q;

	// element register, loaded from a neighbor, the key or the head
	always_ff @(posedge clk) begin
		case (ctl.sel)
			CS_LEFT:  elem_q <= left_in;
			CS_RIGHT: elem_q <= right_in;
			CS_KEY:   elem_q <= key_in;
			CS_WRAP:  elem_q <= head_in;
			default:  elem_q <= elem_q;
		endcase
	end

	assign value_out = elem_q;
	assign hit       = ctl.active && (elem_q == key_in);
	assign tap_out   = ctl.tap ? elem_q : '0;

endmodule
`default_nettype wire

FILE: hdl/ordered_list_engine_unit.sv
// Ordered list engine: top level with command decode, count and the cell chain.
//
// Commands arrive on the cmd channel (cmd_valid/cmd_ready/cmd_data) and results
// leave on the rsp channel (rsp_valid/rsp_ready/rsp_data); a transfer happens
// when valid and ready are both high at a rising clock edge.
// Every command except display on a non-empty list gives one result, registered
// at the command transfer edge. Insert, delete and search shift or compare all
// cells at that edge, so such commands run at one per cycle while each result
// is taken. Display streams the elements head first, one per cycle while
// the receiver takes them, by rotating the cell chain; it holds the command
// channel until the last result, which carries last = 1. The chain ends up
// in its original order. A new command is taken while no display runs and the
// result register is empty or being drained; a stalled receiver holds the
// result and, through cmd_ready, the next command.
// Reset (arst_n low) empties the list and the result register; cell contents
// are not cleared and are only read below the element count.
`default_nettype none
module ordered_list_engine_unit #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	output logic                    cmd_ready,
	input  wire olst_pkg::cmd_item_t cmd_data,
	output logic                    rsp_valid,
	input  wire                     rsp_ready,
	output olst_pkg::rsp_item_t     rsp_data
);
	import olst_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	lst_state_t        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     disp_q, disp_d;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q, rsp_d;
	logic              rsp_load;
	logic              out_free;

	logic              ins_en, del_en, rot_en;
	logic [PW-1:0]     ins_pos, del_pos;
	logic [PW-1:0]     cnt_ext, pos_ext;
	logic              full;
	cmd_t              cmd_e;

	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] cell_tap [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;
	logic [DATA_W-1:0] tap_val;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == LS_IDLE) && out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign cnt_ext = PW'(count_q);
	assign pos_ext = PW'(cmd_data.position);
	assign full    = (count_q == CW'(CAPACITY));
	assign cmd_e   = cmd_t'(cmd_data.command);

	// value of the tapped cell on a delete
	always_comb begin
		tap_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_val = tap_val | cell_tap[i];
		end
	end

	// command decode, display sequencing, next state
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		disp_d   = disp_q;
		rsp_load = 1'b0;
		rsp_d    = '0;
		rsp_d.status = STS_OK;
		rsp_d.last   = 1'b1;
		ins_en   = 1'b0;
		del_en   = 1'b0;
		rot_en   = 1'b0;
		ins_pos  = '0;
		del_pos  = '0;
		case (state_q)
			LS_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					rsp_load = 1'b1;
					if (cmd_e == CMD_CREATE) begin
						if (count_q != '0) begin
							rsp_d.status = STS_CREATED;
						end else begin
							ins_en  = 1'b1;
							count_d = CW'(1);
						end
					end else if (cmd_data.command > 4'(CMD_SEARCH)) begin
						rsp_d.status = STS_OK;
					end else if (count_q == '0) begin
						rsp_d.status = STS_EMPTY;
					end else begin
						case (cmd_e)
							CMD_DISPLAY: begin
								rsp_load = 1'b0;
								state_d  = LS_DISP;
								disp_d   = '0;
							end
							CMD_INS_FRONT, CMD_INS_BACK: begin
								if (full) begin
									rsp_d.status = STS_FULL;
								end else begin
									ins_en  = 1'b1;
									ins_pos = (cmd_e == CMD_INS_FRONT) ? '0 : cnt_ext;
									count_d = count_q + CW'(1);
								end
							end
							CMD_DEL_FRONT, CMD_DEL_BACK: begin
								del_en  = 1'b1;
								del_pos = (cmd_e == CMD_DEL_FRONT) ? '0 : cnt_ext - PW'(1);
								count_d = count_q - CW'(1);
								rsp_d.result_value = tap_val;
							end
							CMD_INS_AT: begin
								if (pos_ext > cnt_ext) begin
									rsp_d.status = STS_RANGE;
								end else if (full) begin
									rsp_d.status = STS_FULL;
								end else begin
									ins_en  = 1'b1;
									ins_pos = pos_ext;
									count_d = count_q + CW'(1);
								end
							end
							CMD_DEL_AT: begin
								if (pos_ext >= cnt_ext) begin
									rsp_d.status = STS_RANGE;
								end else begin
									del_en  = 1'b1;
									del_pos = pos_ext;
									count_d = count_q - CW'(1);
									rsp_d.result_value = tap_val;
								end
							end
							CMD_SEARCH: begin
								rsp_d.found = |hit_vec;
							end
							default: begin
								rsp_d.status = STS_OK;
							end
						endcase
					end
				end
			end
			LS_DISP: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rot_en   = 1'b1;
					rsp_d.result_value = cell_val[0];
					rsp_d.last = (disp_q == count_q - CW'(1));
					if (rsp_d.last) begin
						state_d = LS_IDLE;
						disp_d  = '0;
					end else begin
						disp_d = disp_q + CW'(1);
					end
				end
			end
			default: begin
				state_d = LS_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LS_IDLE;
			count_q     <= '0;
			disp_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			disp_q  <= disp_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// cell chain with per-cell shift control
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [PW-1:0] IDX = PW'(g);
		cell_ctl_t         ctl;
		logic [DATA_W-1:0] left_in, right_in;

		always_comb begin
			ctl.sel    = CS_HOLD;
			ctl.active = (IDX < cnt_ext);
			ctl.tap    = del_en && (IDX == del_pos);
			if (ins_en) begin
				if (IDX > ins_pos) begin
					ctl.sel = CS_LEFT;
				end else if (IDX == ins_pos) begin
					ctl.sel = CS_KEY;
				end
			end else if (del_en) begin
				if ((IDX >= del_pos) && (IDX + PW'(1) < cnt_ext)) begin
					ctl.sel = CS_RIGHT;
				end
			end else if (rot_en) begin
				if (IDX + PW'(1) == cnt_ext) begin
					ctl.sel = CS_WRAP;
				end else if (IDX + PW'(1) < cnt_ext) begin
					ctl.sel = CS_RIGHT;
				end
			end
		end

		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_lastc
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = cell_val[g+1];
		end

		olst_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_in   (left_in),
			.right_in  (right_in),
			.head_in   (cell_val[0]),
			.key_in    (cmd_data.value),
			.value_out (cell_val[g]),
			.hit       (hit_vec[g]),
			.tap_out   (cell_tap[g])
		);
	end

endmodule
`default_nettype wire
